>>> rtl/core/sbgp_pkg.sv
package sbgp_pkg;

  // glyph geometry
  localparam int GlyphWidth  = 8;
  localparam int GlyphHeight = 16;
  localparam int GlyphCount  = 256;

  localparam int ColW   = $clog2(GlyphWidth);
  localparam int LineW  = $clog2(GlyphHeight);
  localparam int GlyphW = $clog2(GlyphCount);
  localparam int AddrW  = GlyphW + LineW;
  localparam int StoreDepth = GlyphCount * GlyphHeight;

  // field widths
  localparam int HeightW = 8;
  localparam int ColorW  = 24;
  localparam int CodeW   = 21;
  localparam int RowW    = 8;
  localparam int PixColW = 7;
  localparam int BitsW   = GlyphWidth;
  localparam int AlphaW  = 8;

  localparam int InDataW  = 56;
  localparam int OutDataW = AlphaW + ColorW;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = ColorW;

  // fixed point
  localparam int FracW   = 16;
  localparam int WeightW = FracW + 1;
  localparam int ProdW   = 2 * FracW + 1;
  localparam int QuoW    = FracW + LineW;
  localparam int XShift  = QuoW - FracW - ColW;
  localparam int RemW    = HeightW;

  // divider pipeline
  localparam int DivSteps  = 4;
  localparam int DivStages = QuoW / DivSteps;

  // width shift from height (GlyphHeight / GlyphWidth is a power of two)
  localparam int WidthShift = LineW - ColW;

  localparam logic [CodeW-1:0] CpFirst = CodeW'(32'h20);
  localparam logic [CodeW-1:0] CpLast  = CodeW'(32'h7E);

  typedef enum logic {
    CmdLoad   = 1'b0,
    CmdRender = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegTextHeight = 1'b0,
    RegFgColor    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_e              cmd;
    logic              inrange;
    logic [GlyphW-1:0] glyph;
    logic [AddrW-1:0]  ld_addr;
    logic [BitsW-1:0]  ld_bits;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [RemW-1:0]  ry;
    logic [QuoW-1:0]  qy;
    logic [RemW-1:0]  rx;
    logic [QuoW-1:0]  qx;
  } div_item_t;

endpackage

>>> rtl/core/sbgp_div_pipe.sv
module sbgp_div_pipe import sbgp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [HeightW-1:0] div_h_i,
  input  logic [HeightW-1:0] div_w_i,
  input  logic               in_valid_i,
  input  div_item_t          in_item_i,
  output logic               out_valid_o,
  output div_item_t          out_item_o
);

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
  } lane_t;

  // restoring division, a few quotient bits per stage
  function automatic lane_t div_steps(input lane_t cur, input logic [RemW-1:0] dv);
    lane_t           nxt;
    logic [RemW:0]   t;
    nxt = cur;
    for (int k = 0; k < DivSteps; k++) begin
      t = {nxt.rem, 1'b0};
      if (t >= {1'b0, dv}) begin
        t = t - {1'b0, dv};
        nxt.quo = {nxt.quo[QuoW-2:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[QuoW-2:0], 1'b0};
      end
      nxt.rem = t[RemW-1:0];
    end
    return nxt;
  endfunction

  logic      valid_q [DivStages];
  div_item_t item_q  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    div_item_t src;
    logic      src_valid;
    div_item_t nxt;
    lane_t     ly;
    lane_t     lx;

    if (s == 0) begin : g_first
      assign src       = in_item_i;
      assign src_valid = in_valid_i;
    end else begin : g_next
      assign src       = item_q[s-1];
      assign src_valid = valid_q[s-1];
    end

    always_comb begin
      ly      = div_steps({src.ry, src.qy}, div_h_i);
      lx      = div_steps({src.rx, src.qx}, div_w_i);
      nxt     = src;
      nxt.ry  = ly.rem;
      nxt.qy  = ly.quo;
      nxt.rx  = lx.rem;
      nxt.qx  = lx.quo;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[s] <= nxt;
      end
    end
  end

  assign out_valid_o = valid_q[DivStages-1];
  assign out_item_o  = item_q[DivStages-1];

endmodule

>>> rtl/core/scaled_bitmap_glyph_pixel.sv
// a render beat passes the input register, the divider pipeline (five stages of four
// quotient bits), the glyph store read, the blend, multiply and sum stages and the output
// register; throughput: one beat per cycle while no output beat is held; a load takes one
// pipeline slot and gives no output; a held output beat stalls every stage at once
// reset clears the valid bits, text_height to 16 and foreground_color to 0
// the glyph store is not cleared and holds junk until loaded
module scaled_bitmap_glyph_pixel import sbgp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // glyph_index, glyph_line, line_bits, code_point, pixel_row, pixel_col
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command
  input  logic                s_axis_tuser,
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_word
  output logic [OutDataW-1:0] m_axis_tdata,
  // register writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [HeightW-1:0] text_height_q;
  logic [ColorW-1:0]  fg_color_q;
  logic [HeightW-1:0] out_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_height_q <= HeightW'(GlyphHeight);
      fg_color_q    <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegTextHeight: text_height_q <= cfg_data_i[HeightW-1:0];
        RegFgColor:    fg_color_q    <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // output width is height * glyph width / glyph height
  assign out_w = text_height_q >> WidthShift;

  // ---------------------------------------------------------------------------
  // global stall: everything moves when the output register can take a beat
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic en;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------------
  // input stage: unpack, map code point, range check, seed the dividers
  // ---------------------------------------------------------------------------
  logic [GlyphW-1:0]  in_gidx;
  logic [LineW-1:0]   in_line;
  logic [BitsW-1:0]   in_bits;
  logic [CodeW-1:0]   in_cp;
  logic [RowW-1:0]    in_row;
  logic [PixColW-1:0] in_col;
  logic [GlyphW-1:0]  in_glyph;
  logic               in_inrange;
  div_item_t          in_item;

  assign in_gidx = s_axis_tdata[7:0];
  assign in_line = s_axis_tdata[11:8];
  assign in_bits = s_axis_tdata[19:12];
  assign in_cp   = s_axis_tdata[40:20];
  assign in_row  = s_axis_tdata[48:41];
  assign in_col  = s_axis_tdata[55:49];

  always_comb begin
    // printable ascii maps to itself, the rest to glyph 0
    if (in_cp >= CpFirst && in_cp <= CpLast) begin
      in_glyph = in_cp[GlyphW-1:0];
    end else begin
      in_glyph = '0;
    end
    // no downscaling; position must fall inside the scaled glyph
    in_inrange = (text_height_q >= HeightW'(GlyphHeight))
              && (in_row < text_height_q)
              && ({1'b0, in_col} < out_w);

    in_item.meta.cmd     = cmd_e'(s_axis_tuser);
    in_item.meta.inrange = in_inrange;
    in_item.meta.glyph   = in_glyph;
    in_item.meta.ld_addr = {in_gidx, in_line};
    in_item.meta.ld_bits = in_bits;
    // row < height and col < width, so the first quotient bits are zero
    in_item.ry = RemW'(in_row);
    in_item.qy = '0;
    in_item.rx = RemW'(in_col);
    in_item.qx = '0;
  end

  logic      in_valid_q;
  div_item_t in_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_item_q <= in_item;
    end
  end

  // ---------------------------------------------------------------------------
  // divider pipeline: yf = row * 2^20 / height, 2 * xf = col * 2^20 / width
  // ---------------------------------------------------------------------------
  logic      dv_valid;
  div_item_t dv_item;

  sbgp_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .div_h_i     (text_height_q),
    .div_w_i     (out_w),
    .in_valid_i  (in_valid_q),
    .in_item_i   (in_item_q),
    .out_valid_o (dv_valid),
    .out_item_o  (dv_item)
  );

  // ---------------------------------------------------------------------------
  // glyph store stage: loads write here, renders read two rows here, so
  // every render sees exactly the loads that came before it
  // ---------------------------------------------------------------------------
  logic [QuoW-1:0]   dv_xf;
  logic [LineW-1:0]  dv_iy;
  logic [LineW-1:0]  dv_iy1;
  logic [AddrW-1:0]  dv_addr0;
  logic [AddrW-1:0]  dv_addr1;
  logic              dv_render;

  assign dv_xf     = dv_item.qx >> XShift;
  assign dv_iy     = dv_item.qy[QuoW-1 -: LineW];
  assign dv_iy1    = dv_iy + LineW'(1);
  assign dv_addr0  = {dv_item.meta.glyph, dv_iy};
  assign dv_addr1  = {dv_item.meta.glyph, dv_iy1};
  assign dv_render = dv_valid && (dv_item.meta.cmd == CmdRender);

  logic [BitsW-1:0] glyph_mem [StoreDepth];

  logic             rd_valid_q;
  logic             rd_inrange_q;
  logic [ColW-1:0]  rd_ix_q;
  logic [FracW-1:0] rd_fx_q;
  logic [FracW-1:0] rd_fy_q;
  logic             rd_row1_q;
  logic [BitsW-1:0] rd_line0_q;
  logic [BitsW-1:0] rd_line1_q;

  always_ff @(posedge clk_i) begin
    if (en && dv_valid && (dv_item.meta.cmd == CmdLoad)) begin
      glyph_mem[dv_item.meta.ld_addr] <= dv_item.meta.ld_bits;
    end
    if (en) begin
      rd_line0_q <= glyph_mem[dv_addr0];
      rd_line1_q <= glyph_mem[dv_addr1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (en) begin
      rd_valid_q <= dv_render;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_inrange_q <= dv_item.meta.inrange;
      rd_ix_q      <= dv_xf[FracW +: ColW];
      rd_fx_q      <= dv_xf[FracW-1:0];
      rd_fy_q      <= dv_item.qy[FracW-1:0];
      // the row below the last glyph row reads as blank
      rd_row1_q    <= (dv_iy != LineW'(GlyphHeight - 1));
    end
  end

  // ---------------------------------------------------------------------------
  // blend stage: horizontal weights applied per row by selection
  // ---------------------------------------------------------------------------
  logic               b00;
  logic               b10;
  logic               b01;
  logic               b11;
  logic               col1_ok;
  logic [ColW-1:0]    bit0_idx;
  logic [ColW-1:0]    bit1_idx;
  logic [WeightW-1:0] wx0;
  logic [WeightW-1:0] wx1;
  logic [WeightW-1:0] h0_d;
  logic [WeightW-1:0] h1_d;

  always_comb begin
    // msb is the leftmost column; the column right of the glyph reads as blank
    col1_ok  = (rd_ix_q != ColW'(GlyphWidth - 1));
    bit0_idx = ColW'(GlyphWidth - 1) - rd_ix_q;
    bit1_idx = bit0_idx - ColW'(1);
    b00 = rd_line0_q[bit0_idx];
    b10 = rd_line0_q[bit1_idx] && col1_ok;
    b01 = rd_line1_q[bit0_idx] && rd_row1_q;
    b11 = rd_line1_q[bit1_idx] && col1_ok && rd_row1_q;
    wx1 = {1'b0, rd_fx_q};
    wx0 = {1'b1, {FracW{1'b0}}} - wx1;
    h0_d = (b00 ? wx0 : '0) + (b10 ? wx1 : '0);
    h1_d = (b01 ? wx0 : '0) + (b11 ? wx1 : '0);
  end

  logic               bl_valid_q;
  logic               bl_inrange_q;
  logic [WeightW-1:0] bl_h0_q;
  logic [WeightW-1:0] bl_h1_q;
  logic [WeightW-1:0] bl_wy0_q;
  logic [WeightW-1:0] bl_wy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_valid_q <= 1'b0;
    end else if (en) begin
      bl_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bl_inrange_q <= rd_inrange_q;
      bl_h0_q      <= h0_d;
      bl_h1_q      <= h1_d;
      bl_wy0_q     <= {1'b1, {FracW{1'b0}}} - {1'b0, rd_fy_q};
      bl_wy1_q     <= {1'b0, rd_fy_q};
    end
  end

  // ---------------------------------------------------------------------------
  // multiply stage: vertical weights, one 17x17 product per row
  // ---------------------------------------------------------------------------
  logic [2*WeightW-1:0] p0_full;
  logic [2*WeightW-1:0] p1_full;

  assign p0_full = {{WeightW{1'b0}}, bl_h0_q} * {{WeightW{1'b0}}, bl_wy0_q};
  assign p1_full = {{WeightW{1'b0}}, bl_h1_q} * {{WeightW{1'b0}}, bl_wy1_q};

  logic             mu_valid_q;
  logic             mu_inrange_q;
  logic [ProdW-1:0] mu_p0_q;
  logic [ProdW-1:0] mu_p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_valid_q <= 1'b0;
    end else if (en) begin
      mu_valid_q <= bl_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_inrange_q <= bl_inrange_q;
      mu_p0_q      <= p0_full[ProdW-1:0];
      mu_p1_q      <= p1_full[ProdW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sum stage: total weight of the set bits, at most 2^32
  // ---------------------------------------------------------------------------
  logic             sm_valid_q;
  logic             sm_inrange_q;
  logic [ProdW-1:0] sm_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_valid_q <= 1'b0;
    end else if (en) begin
      sm_valid_q <= mu_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_inrange_q <= mu_inrange_q;
      sm_v_q       <= mu_p0_q + mu_p1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // output register: alpha = floor(255 * sum / 2^32), colour underneath
  // ---------------------------------------------------------------------------
  logic [ProdW+AlphaW-1:0] scaled;
  logic [AlphaW-1:0]       alpha;
  logic [OutDataW-1:0]     out_data_q;

  assign scaled = {sm_v_q, {AlphaW{1'b0}}} - {{AlphaW{1'b0}}, sm_v_q};
  assign alpha  = sm_inrange_q ? scaled[2*FracW +: AlphaW] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sm_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {alpha, fg_color_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an output beat only ever comes from a render in the sum stage
  a_out_from_render: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(sm_valid_q))
    else $error("output beat without a render behind it");

  // in-range items leave the divider with proper remainders
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid && dv_item.meta.inrange) |->
      (dv_item.ry < text_height_q) && (dv_item.rx < out_w))
    else $error("divider remainder not below divisor");

  // the bilinear weights of the four bits never add to more than one
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sm_valid_q |-> (sm_v_q <= {1'b1, {(2*FracW){1'b0}}}))
    else $error("blend weight sum above one");

  // a held output beat blocks the input side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output is stalled");

endmodule

>>> test/scaled_bitmap_glyph_pixel_test.sv
module scaled_bitmap_glyph_pixel_test;
  import sbgp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // input beat layout, lowest field first
  localparam int IdxLo  = 0;
  localparam int LineLo = IdxLo + GlyphW;
  localparam int BitsLo = LineLo + LineW;
  localparam int CpLo   = BitsLo + BitsW;
  localparam int RowLo  = CpLo + CodeW;
  localparam int ColLo  = RowLo + RowW;

  // pipeline is 11 deep; loads leave no trace at the output, so give it room
  localparam int SettleCycles = 24;
  // no handshake for this many cycles means the block is stuck
  localparam int StallLimit   = 5000;
  localparam int NumPhases    = 11;
  localparam int MixedPerPhase = 76;

  typedef struct {
    cmd_e               cmd;
    logic [InDataW-1:0] data;
  } glyph_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  scaled_bitmap_glyph_pixel u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // commands waiting to be driven, and pixel words waiting to come out
  glyph_cmd_t        glyph_cmds[$];
  logic [OutDataW-1:0] expected_pixels[$];

  // predictor state: its own font copy and register shadows
  logic [BitsW-1:0]   font_rows[StoreDepth];
  logic [HeightW-1:0] height_q = HeightW'(16);
  logic [ColorW-1:0]  color_q = '0;

  // stimulus side bookkeeping: printable glyphs whose lines have all been queued
  int unsigned            ready_glyphs[$];

  int  mismatches = 0;
  bit  calm = 1'b0;        // no idling on either side once set
  bit  in_taken = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  // one glyph bit worth 0 or 255; anything off the glyph is dark
  function automatic longint unsigned glyph_bit(int unsigned glyph, int unsigned x,
                                                int unsigned y);
    logic [BitsW-1:0] line;
    if (x >= GlyphWidth || y >= GlyphHeight) return 0;
    line = font_rows[glyph * GlyphHeight + y];
    return line[GlyphWidth - 1 - x] ? 64'd255 : 64'd0;
  endfunction

  // alpha over colour for one scaled glyph pixel
  function automatic logic [OutDataW-1:0] glyph_pixel_word(logic [CodeW-1:0] cp,
                                                          logic [RowW-1:0] row,
                                                          logic [PixColW-1:0] col);
    int unsigned       glyph, ix, iy;
    longint unsigned   out_h, out_w, yf, xf, fx, fy, sum;
    logic [AlphaW-1:0] alpha;
    glyph = (cp >= CpFirst && cp <= CpLast) ? int'(cp) : 0;
    out_h = height_q;
    out_w = out_h * GlyphWidth / GlyphHeight;
    alpha = '0;
    if (out_h >= GlyphHeight && out_w != 0 && row < out_h && col < out_w) begin
      // pixel position mapped back into the glyph, 16.16
      yf = (64'(row) * GlyphHeight << FracW) / out_h;
      xf = (64'(col) * GlyphWidth << FracW) / out_w;
      ix = int'(xf >> FracW);
      iy = int'(yf >> FracW);
      fx = xf & 64'hFFFF;
      fy = yf & 64'hFFFF;
      sum = glyph_bit(glyph, ix, iy) * (64'h10000 - fx) * (64'h10000 - fy)
          + glyph_bit(glyph, ix + 1, iy) * fx * (64'h10000 - fy)
          + glyph_bit(glyph, ix, iy + 1) * (64'h10000 - fx) * fy
          + glyph_bit(glyph, ix + 1, iy + 1) * fx * fy;
      alpha = sum[39:32];
    end
    return {alpha, color_q};
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  task automatic queue_load(int unsigned glyph, int unsigned line, logic [BitsW-1:0] bits);
    logic [InDataW-1:0] d;
    d = '0;
    d[IdxLo +: GlyphW] = GlyphW'(glyph);
    d[LineLo +: LineW] = LineW'(line);
    d[BitsLo +: BitsW] = bits;
    // random filler in the render fields, a load must not care
    d[CpLo +: CodeW]     = CodeW'($urandom);
    d[RowLo +: RowW]     = RowW'($urandom);
    d[ColLo +: PixColW]  = PixColW'($urandom);
    glyph_cmds.push_back('{CmdLoad, d});
  endtask

  task automatic queue_render(logic [CodeW-1:0] cp, logic [RowW-1:0] row,
                              logic [PixColW-1:0] col);
    logic [InDataW-1:0] d;
    d = '0;
    d[IdxLo +: GlyphW]  = GlyphW'($urandom);
    d[LineLo +: LineW]  = LineW'($urandom);
    d[BitsLo +: BitsW]  = BitsW'($urandom);
    d[CpLo +: CodeW]    = cp;
    d[RowLo +: RowW]    = row;
    d[ColLo +: PixColW] = col;
    glyph_cmds.push_back('{CmdRender, d});
  endtask

  // whole glyph, top line down, with a mix of solid, empty, edge-column and random lines
  task automatic queue_glyph(int unsigned glyph);
    logic [BitsW-1:0] bits;
    for (int l = 0; l < GlyphHeight; l++) begin
      case ($urandom_range(0, 5))
        0:       bits = '1;
        1:       bits = '0;
        2:       bits = BitsW'(8'h81);
        default: bits = BitsW'($urandom);
      endcase
      queue_load(glyph, l, bits);
    end
    if (glyph >= CpFirst && glyph <= CpLast) begin
      if (ready_glyphs.size() == 0 || !(glyph inside {ready_glyphs})) ready_glyphs.push_back(glyph);
    end
  endtask

  // render a glyph whose lines have all been loaded, mostly inside the glyph box
  task automatic queue_random_render();
    logic [CodeW-1:0]   cp;
    logic [RowW-1:0]    row;
    logic [PixColW-1:0] col;
    int unsigned        out_h, out_w;
    out_h = height_q;
    out_w = out_h * GlyphWidth / GlyphHeight;
    if (ready_glyphs.size() != 0 && $urandom_range(0, 9) < 6) begin
      cp = CodeW'(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]);
    end else begin
      // anything non-printable lands on glyph 0
      cp = $urandom_range(0, 1) ? CodeW'($urandom) : CodeW'($urandom_range(0, 255));
      while (cp >= CpFirst && cp <= CpLast) cp = CodeW'($urandom);
    end
    if (out_h >= GlyphHeight && $urandom_range(0, 7) != 0) begin
      row = RowW'($urandom_range(0, out_h - 1));
      col = PixColW'($urandom_range(0, out_w - 1));
      case ($urandom_range(0, 15))
        0: begin
          row = '0;
          col = '0;
        end
        1: begin
          row = RowW'(out_h - 1);
          col = PixColW'(out_w - 1);
        end
        default: ;
      endcase
    end else begin
      row = RowW'($urandom);
      col = PixColW'($urandom);
    end
    queue_render(cp, row, col);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == RegTextHeight) height_q = value[HeightW-1:0];
    else color_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold off until the block has drained, then let any trailing load settle
  task automatic wait_idle();
    while (glyph_cmds.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one beat held until taken, random gaps between beats
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive_input
    glyph_cmd_t item;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && glyph_cmds.size() != 0 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(1, 16) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (glyph_cmds.size() != 0) begin
        item = glyph_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.data;
        s_axis_tuser  <= item.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // accepted input beat: loads update the font copy, renders predict a word
  always @(posedge clk_i) begin : take_input
    logic [GlyphW-1:0]  idx;
    logic [LineW-1:0]   line;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      in_taken = 1'b1;
      if (s_axis_tuser == CmdLoad) begin
        idx  = s_axis_tdata[IdxLo +: GlyphW];
        line = s_axis_tdata[LineLo +: LineW];
        font_rows[{idx, line}] = s_axis_tdata[BitsLo +: BitsW];
      end else begin
        expected_pixels.push_back(glyph_pixel_word(s_axis_tdata[CpLo +: CodeW],
                                                   s_axis_tdata[RowLo +: RowW],
                                                   s_axis_tdata[ColLo +: PixColW]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: random stall bursts, every beat checked in order
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_output
    logic [OutDataW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel_word beat, actual %08h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: pixel_word mismatch, expected %08h actual %08h",
                   $time, want, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  // stuck detector: counts cycles with no handshake and no register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    logic [HeightW-1:0] heights[NumPhases];
    logic [CfgDataW-1:0] colors[NumPhases];
    logic [CfgDataW-1:0] hword;
    int unsigned        g;

    heights = '{8'd255, 8'd16, 8'd17, 8'd31, 8'd64, 8'd0, 8'd15, 8'd200,
                HeightW'($urandom_range(16, 255)), HeightW'($urandom_range(16, 255)), 8'd255};
    for (int i = 0; i < NumPhases; i++) colors[i] = CfgDataW'($urandom);
    colors[0] = '1;
    colors[1] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: glyph 0 with extreme line patterns, then renders at the reset
    // height and colour, including the non-printable map and off-glyph positions
    queue_load(0, 0, 8'h00);
    queue_load(0, 1, 8'hFF);
    queue_load(0, 2, 8'h80);
    queue_load(0, 3, 8'h01);
    for (int l = 4; l < GlyphHeight; l++) queue_load(0, l, BitsW'($urandom));
    queue_render(CodeW'(0), 8'd0, 7'd0);
    queue_render(CodeW'(21'h1F), 8'd1, 7'd7);       // right edge, neighbor off the glyph
    queue_render(CodeW'(21'h7F), 8'd15, 7'd3);      // bottom line, neighbor below is off
    queue_render('1, 8'd2, 7'd0);                   // all-ones code point
    queue_render(CodeW'(21'h10FFFF), 8'd3, 7'd5);
    queue_render(CodeW'(0), 8'd16, 7'd0);           // row just past the glyph box
    queue_render(CodeW'(0), 8'd0, 7'd8);            // column just past the glyph box
    queue_render(CodeW'(0), 8'd255, 7'd127);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) calm = 1'b1;
      hword = CfgDataW'({16'($urandom_range(0, 1) ? $urandom : 0), heights[p]});
      write_reg(RegTextHeight, hword);
      write_reg(RegFgColor, colors[p]);

      // one or two fresh glyphs, mostly printable ones, then mixed traffic
      for (int n = $urandom_range(1, 2); n > 0; n--) begin
        if ($urandom_range(0, 3) == 0) g = $urandom_range(0, GlyphCount - 1);
        else g = $urandom_range(CpFirst, CpLast);
        queue_glyph(g);
      end
      for (int i = 0; i < MixedPerPhase; i++) begin
        if ($urandom_range(0, 9) == 0)
          queue_load($urandom_range(0, GlyphCount - 1), $urandom_range(0, GlyphHeight - 1),
                     BitsW'($urandom));
        else
          queue_random_render();
      end
      // the sender stops here until every expected word is back
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> scaled_bitmap_glyph_pixel.f
rtl/core/sbgp_pkg.sv
rtl/core/sbgp_div_pipe.sv
rtl/core/scaled_bitmap_glyph_pixel.sv
test/scaled_bitmap_glyph_pixel_test.sv
